// ===== src/jhcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jhcd_pkg: shared constants and huffman tables
// fixed baseline luminance dc/ac code tables and field widths
// ---------------------------------------------------------------------------
package jhcd_pkg;

    localparam int DEF_MAX_BLOCKS = 16;
    localparam int BUF_W          = 40;
    localparam int AC_NSYM        = 162;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_DC  = 2'd1;
    localparam logic [1:0] ST_RUN_OVF = 2'd2;
    localparam logic [1:0] ST_NO_DATA = 2'd3;

    typedef logic [7:0] t_byte;

    // number of dc codes of each length
    function automatic t_byte dc_cnt(input logic [4:0] len);
        t_byte c;
        case (len)
            5'd2:    c = 8'd1;
            5'd3:    c = 8'd5;
            5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9: c = 8'd1;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // number of ac codes of each length
    function automatic t_byte ac_cnt(input logic [4:0] len);
        t_byte c;
        case (len)
            5'd2:    c = 8'd2;
            5'd3:    c = 8'd1;
            5'd4:    c = 8'd3;
            5'd5:    c = 8'd3;
            5'd6:    c = 8'd2;
            5'd7:    c = 8'd4;
            5'd8:    c = 8'd3;
            5'd9:    c = 8'd5;
            5'd10:   c = 8'd5;
            5'd11:   c = 8'd4;
            5'd12:   c = 8'd4;
            5'd15:   c = 8'd1;
            5'd16:   c = 8'd125;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // ac symbols in code order, high nibble run, low nibble category
    localparam t_byte AC_SYM [AC_NSYM] = '{
        8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41,
        8'h06, 8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91,
        8'ha1, 8'h08, 8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0, 8'h24,
        8'h33, 8'h62, 8'h72, 8'h82,
        8'h09, 8'h0a, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a,
        8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a,
        8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a,
        8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a,
        8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a,
        8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a,
        8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa,
        8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba,
        8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca,
        8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda,
        8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea,
        8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa
    };

endpackage

`default_nettype wire

// ===== src/jpeg_huffman_coefficient_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jpeg huffman coefficient decoder core
// decodes baseline luminance dc/ac huffman symbols into coefficient beats
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one compressed byte per beat (msb first); tuser is the
//   packet start flag, tlast marks the final byte of the packet.
//   m_axis carries one beat per decoded symbol; tlast is block end, tuser
//   holds packet done and status. implied zeros are not sent.
//   i_cfg_we/i_cfg_wdata set the number of blocks per packet (reset 14).
// timing:
//   s_axis_tready is high only while the sequencer is idle. after a byte is
//   accepted, each symbol decoded from it (at most four) passes through
//   the init, walk, symbol, magnitude, apply and emit states: the code is
//   walked bit-serially through the shared compare unit, then the
//   magnitude bits are read; the walk also covers the bits of a code that
//   is not yet complete. an end of block skips magnitude and apply.
// reset and stall:
//   synchronous active-low reset clears sequencer state, counters and output valid.
//   a stalled m_axis holds its beat; the sequencer waits on the next
//   result until the output register frees up, nothing is dropped.
// ---------------------------------------------------------------------------
module jpeg_huffman_coefficient_decoder_core
    import jhcd_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave side
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] packet_start
    input  wire         s_axis_tlast,   // last_byte
    // master side
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] block_number, [9:4] coef_position,
                                        // [25:10] coef_value, [31:26] zero
    output logic [2:0]  m_axis_tuser,   // [0] packet_done, [2:1] status
    output logic        m_axis_tlast,   // block_end
    // configuration
    input  wire         i_cfg_we,
    input  wire  [4:0]  i_cfg_wdata
);

    localparam int CAP = (MAX_BLOCKS < 16) ? MAX_BLOCKS : 16;
    localparam logic [4:0] CAP_V = 5'(CAP);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_WALK  = 4'd2;
    localparam logic [3:0] S_NOHIT = 4'd3;
    localparam logic [3:0] S_SYM   = 4'd4;
    localparam logic [3:0] S_MAG   = 4'd5;
    localparam logic [3:0] S_APPLY = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]  r_state, r_ret;
    logic [BUF_W-1:0] r_buf;
    logic [5:0]  r_held;
    logic [15:0] r_pred;
    logic [4:0]  r_blk;
    logic [5:0]  r_coef;
    logic        r_halt;
    logic [4:0]  r_cfg;
    logic        r_last;
    logic [2:0]  r_iter;
    logic        r_dc;
    logic [4:0]  r_cur;     // bits read so far in this symbol
    logic [15:0] r_w;
    logic [16:0] r_first;
    logic [7:0]  r_base;
    logic [4:0]  r_len;
    logic [7:0]  r_idx;
    logic [3:0]  r_run;
    logic [3:0]  r_cat;
    logic [15:0] r_x;
    // pending result
    logic [3:0]  r_e_blk;
    logic [5:0]  r_e_pos;
    logic [15:0] r_e_val;
    logic        r_e_end, r_e_pd;
    logic [1:0]  r_e_st;
    // output register
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic [2:0]  r_ouser;
    logic        r_olast;

    // clamped block limit
    logic [4:0] n_limit;
    always_comb begin
        n_limit = r_cfg;
        if (n_limit > CAP_V) n_limit = CAP_V;
        if (n_limit == 5'd0) n_limit = 5'd1;
    end

    // shared bit read and code compare unit
    logic [5:0]  rd_idx;
    logic        rd_bit;
    logic [15:0] n_w;
    logic [16:0] n_diff;
    logic [7:0]  n_cnt;
    logic        n_hit;
    logic [4:0]  n_l;
    logic [4:0]  maxlen;
    always_comb begin
        rd_idx = r_held - 6'd1 - {1'b0, r_cur};
        rd_bit = r_buf[rd_idx];
        n_w    = {r_w[14:0], rd_bit};
        n_diff = {1'b0, n_w} - r_first;
        n_l    = r_cur + 5'd1;
        n_cnt  = r_dc ? dc_cnt(n_l) : ac_cnt(n_l);
        n_hit  = !n_diff[16] && (n_diff[15:0] < {8'd0, n_cnt});
        maxlen = r_dc ? 5'd9 : 5'd16;
    end

    // symbol fields and bit need
    logic [7:0] n_sym;
    logic [3:0] n_run, n_cat;
    logic [5:0] n_need;
    logic [6:0] n_runpos;
    always_comb begin
        n_sym    = (r_idx < 8'(AC_NSYM)) ? AC_SYM[r_idx] : AC_SYM[0];
        n_run    = r_dc ? 4'd0 : n_sym[7:4];
        n_cat    = r_dc ? r_idx[3:0] : n_sym[3:0];
        n_need   = {1'b0, r_len} + {2'b0, r_cat};
        n_runpos = {1'b0, r_coef} + {3'b0, r_run};
    end

    // magnitude recovery
    logic [15:0] n_mask, n_mag;
    logic [3:0]  cat_m1;
    always_comb begin
        n_mask = (16'd1 << r_cat) - 16'd1;
        cat_m1 = r_cat - 4'd1;
        if (r_cat == 4'd0)      n_mag = 16'd0;
        else if (r_x[cat_m1])   n_mag = r_x;
        else                    n_mag = r_x - n_mask;
    end

    logic [4:0] n_nblk;
    logic       n_pd;
    assign n_nblk = r_blk + 5'd1;
    assign n_pd   = (n_nblk >= n_limit);

    logic out_free;
    assign out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_held   <= '0;
            r_pred   <= '0;
            r_blk    <= '0;
            r_coef   <= '0;
            r_halt   <= 1'b0;
            r_cfg    <= 5'd14;
            r_ovalid <= 1'b0;
            r_iter   <= '0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            // the emit state reloads the output register itself
            if (r_ovalid && m_axis_tready && r_state != S_EMIT) r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser) begin
                            r_pred <= '0;
                            r_blk  <= '0;
                            r_coef <= '0;
                            r_halt <= 1'b0;
                        end
                        if (!r_halt || s_axis_tuser) begin
                            // fresh packet restarts the bit buffer
                            r_buf  <= {r_buf[BUF_W-9:0], s_axis_tdata};
                            r_held <= (s_axis_tuser ? 6'd0 : r_held) + 6'd8;
                            r_last <= s_axis_tlast;
                            r_iter <= '0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (r_iter == 3'd4) begin
                        r_state <= S_FIN;
                    end else begin
                        r_dc    <= (r_coef == 6'd0);
                        r_cur   <= '0;
                        r_w     <= '0;
                        r_first <= '0;
                        r_base  <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // one code bit per cycle
                    if ({1'b0, r_cur} >= r_held) begin
                        r_state <= S_FIN;
                    end else if (n_hit) begin
                        r_len   <= n_l;
                        r_idx   <= r_base + n_diff[7:0];
                        r_cur   <= n_l;
                        r_state <= S_SYM;
                    end else begin
                        r_w     <= n_w;
                        r_base  <= r_base + n_cnt;
                        r_first <= ({r_first[15:0], 1'b0} + {8'd0, n_cnt, 1'b0});
                        r_cur   <= n_l;
                        if (n_l == maxlen) r_state <= S_NOHIT;
                    end
                end
                S_NOHIT: begin
                    if (r_dc) begin
                        r_e_blk <= r_blk[3:0];
                        r_e_pos <= r_coef;
                        r_e_val <= '0;
                        r_e_end <= 1'b0;
                        r_e_pd  <= 1'b0;
                        r_e_st  <= ST_BAD_DC;
                        r_halt  <= 1'b1;
                        r_held  <= '0;
                        r_ret   <= S_FIN;
                        r_state <= S_EMIT;
                    end else if (r_held < 6'd17) begin
                        r_state <= S_FIN;
                    end else begin
                        // sixteen ones taken as end of block
                        r_len   <= 5'd17;
                        r_idx   <= 8'd3;
                        r_state <= S_SYM;
                    end
                end
                S_SYM: begin
                    r_run <= n_run;
                    r_cat <= n_cat;
                    r_x   <= '0;
                    if (!r_dc && n_run == 4'd0 && n_cat == 4'd0) begin
                        // end of block
                        r_e_blk <= r_blk[3:0];
                        r_e_pos <= '0;
                        r_e_val <= '0;
                        r_e_end <= 1'b1;
                        r_e_pd  <= n_pd;
                        r_e_st  <= ST_OK;
                        r_blk   <= n_nblk;
                        r_coef  <= '0;
                        if (n_pd) begin
                            r_halt <= 1'b1;
                            r_held <= '0;
                            r_ret  <= S_FIN;
                        end else begin
                            r_held <= r_held - {1'b0, r_len};
                            r_ret  <= S_INIT;
                        end
                        r_iter  <= r_iter + 3'd1;
                        r_state <= S_EMIT;
                    end else if (!r_dc && ({1'b0, r_coef} + {3'b0, n_run}) >= 7'd64) begin
                        r_e_blk <= r_blk[3:0];
                        r_e_pos <= r_coef;
                        r_e_val <= '0;
                        r_e_end <= 1'b0;
                        r_e_pd  <= 1'b0;
                        r_e_st  <= ST_RUN_OVF;
                        r_halt  <= 1'b1;
                        r_held  <= '0;
                        r_ret   <= S_FIN;
                        r_state <= S_EMIT;
                    end else if (({1'b0, r_len} + {2'b0, n_cat}) > r_held) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    // one magnitude bit per cycle
                    if ({1'b0, r_cur} == n_need) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_x   <= {r_x[14:0], rd_bit};
                        r_cur <= r_cur + 5'd1;
                    end
                end
                S_APPLY: begin
                    r_e_blk <= r_blk[3:0];
                    r_e_st  <= ST_OK;
                    r_iter  <= r_iter + 3'd1;
                    if (r_dc) begin
                        r_held  <= r_held - n_need;
                        r_e_pd  <= 1'b0;
                        r_e_end <= 1'b0;
                        r_ret   <= S_INIT;
                        r_pred  <= r_pred + n_mag;
                        r_e_pos <= '0;
                        r_e_val <= r_pred + n_mag;
                        r_coef  <= 6'd1;
                    end else begin
                        r_e_pos <= n_runpos[5:0];
                        r_e_val <= n_mag;
                        if (n_runpos[5:0] == 6'd63) begin
                            r_e_end <= 1'b1;
                            r_e_pd  <= n_pd;
                            r_blk   <= n_nblk;
                            r_coef  <= '0;
                            if (n_pd) begin
                                r_halt <= 1'b1;
                                r_held <= '0;
                                r_ret  <= S_FIN;
                            end else begin
                                r_held <= r_held - n_need;
                                r_ret  <= S_INIT;
                            end
                        end else begin
                            r_e_end <= 1'b0;
                            r_e_pd  <= 1'b0;
                            r_held  <= r_held - n_need;
                            r_ret   <= S_INIT;
                            r_coef  <= n_runpos[5:0] + 6'd1;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_FIN: begin
                    if (!r_halt && r_last) begin
                        r_e_blk <= r_blk[3:0];
                        r_e_pos <= r_coef;
                        r_e_val <= '0;
                        r_e_end <= 1'b0;
                        r_e_pd  <= 1'b0;
                        r_e_st  <= ST_NO_DATA;
                        r_halt  <= 1'b1;
                        r_held  <= '0;
                        r_ret   <= S_IDLE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {6'd0, r_e_val, r_e_pos, r_e_blk};
                        r_ouser  <= {r_e_st, r_e_pd};
                        r_olast  <= r_e_end;
                        r_state  <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
